>>> rtl/rbpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpp_pkg
// shared constants, types and helpers of the rotated bitplane pixel plotter
// ----------------------------------------------------------------------------
package rbpp_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 176;
    localparam int PANEL_HEIGHT = 264;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_DEPTH  = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // field widths
    localparam int KIND_W   = 2;
    localparam int POS_W    = 9;
    localparam int COLOR_W  = 16;
    localparam int BIDX_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // coordinate and address arithmetic
    localparam int CALC_W     = 10;
    localparam int IDX_CALC_W = 16;

    localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0] MSB_MASK      = 8'h80;
    localparam int                GRAY_SHIFT    = 6;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 1'd1;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_FILL,
        OP_READ
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] idx;
        logic [BYTE_W-1:0] mask;
        logic              sel_mono;
        logic              mono_val;
        logic              p1_val;
        logic              p2_val;
        logic              oor;
    } cmd_t;

    // gray level to plane bits: bit0 plane one, bit1 plane two
    function automatic logic [1:0] gray_pattern(input logic [COLOR_W-1:0] color);
        logic [COLOR_W-GRAY_SHIFT-1:0] level;
        level = color[COLOR_W-1:GRAY_SHIFT];
        case (level)
            10'd1:   gray_pattern = 2'b10;
            10'd2:   gray_pattern = 2'b01;
            10'd3:   gray_pattern = 2'b00;
            default: gray_pattern = 2'b11;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/rotated_bitplane_pixel_plotter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_bitplane_pixel_plotter
// mono framebuffer and two gray bitplanes with rotated pixel plotting
// ----------------------------------------------------------------------------
// a read is popped by the idle back end into the command register as its ram
//   read issues, then returned through the result registers; a read past the end
//   of the store skips the ram read. draws and fills raise no done. a draw or read
//   holds the back end for a ram read, then write or result; a fill writes the whole store, one byte per cycle
// busy rises while the two-entry command queue is full; results cannot be held off
// reset: mono mode on, rotation 0, queue empty; stores undefined until written, no clearing pass
module rotated_bitplane_pixel_plotter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [rbpp_pkg::KIND_W-1:0]     kind,
    input  wire logic [rbpp_pkg::POS_W-1:0]      pos_x,
    input  wire logic [rbpp_pkg::POS_W-1:0]      pos_y,
    input  wire logic [rbpp_pkg::COLOR_W-1:0]    color,
    input  wire logic [rbpp_pkg::BIDX_W-1:0]     byte_index,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [rbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data,
    // result channel
    output logic                                 done,
    output logic [rbpp_pkg::BYTE_W-1:0]          mono_byte,
    output logic [rbpp_pkg::BYTE_W-1:0]          plane_one_byte,
    output logic [rbpp_pkg::BYTE_W-1:0]          plane_two_byte
);
    import rbpp_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;

    // a transaction is taken whenever start is high and the queue has room
    assign busy   = full;
    assign accept = start && !full;

    // front: holds config, bounds-checks, rotates and turns items into commands
    rbpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .kind       (kind),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .color      (color),
        .byte_index (byte_index),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // short queue decouples classification from ram access
    rbpp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    // back: owns the three stores, runs read-modify-write, fill sweep and reads
    rbpp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .done           (done),
        .mono_byte      (mono_byte),
        .plane_one_byte (plane_one_byte),
        .plane_two_byte (plane_two_byte)
    );

endmodule
`default_nettype wire

>>> rtl/rbpp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rbpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/rbpp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpp_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module rbpp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rbpp_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output rbpp_pkg::cmd_t     head,
    output logic               empty
);
    import rbpp_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg            <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/rbpp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpp_front
// configuration registers, bounds check, rotation and address calculation
// ----------------------------------------------------------------------------
module rbpp_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rbpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbpp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            accept,
    input  wire logic [rbpp_pkg::KIND_W-1:0]     kind,
    input  wire logic [rbpp_pkg::POS_W-1:0]      pos_x,
    input  wire logic [rbpp_pkg::POS_W-1:0]      pos_y,
    input  wire logic [rbpp_pkg::COLOR_W-1:0]    color,
    input  wire logic [rbpp_pkg::BIDX_W-1:0]     byte_index,
    output logic                                 push,
    output rbpp_pkg::cmd_t                       push_cmd
);
    import rbpp_pkg::*;

    logic       mono_mode_reg;
    logic [1:0] rotation_reg;

    logic [CALC_W-1:0]     x_ext;
    logic [CALC_W-1:0]     y_ext;
    logic [CALC_W-1:0]     lim_x;
    logic [CALC_W-1:0]     lim_y;
    logic [CALC_W-1:0]     px;
    logic [CALC_W-1:0]     py;
    logic [IDX_CALC_W-1:0] idx_full;
    logic [IDX_CALC_W-1:0] bidx_ext;
    logic                  on_panel;
    logic                  idx_ok;
    logic [1:0]            pat;
    logic                  color_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_mode_reg <= 1'b1;
            rotation_reg  <= ROT_0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MONO_MODE: mono_mode_reg <= cfg_data[0];
                CFG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        x_ext = CALC_W'(pos_x);
        y_ext = CALC_W'(pos_y);
        lim_x = rotation_reg[0] ? CALC_W'(PANEL_HEIGHT) : CALC_W'(PANEL_WIDTH);
        lim_y = rotation_reg[0] ? CALC_W'(PANEL_WIDTH) : CALC_W'(PANEL_HEIGHT);
        on_panel = (x_ext < lim_x) && (y_ext < lim_y);

        unique case (rotation_reg)
            ROT_90:
            begin
                px = CALC_W'(PANEL_WIDTH - 1) - y_ext;
                py = x_ext;
            end
            ROT_180:
            begin
                px = CALC_W'(PANEL_WIDTH - 1) - x_ext;
                py = CALC_W'(PANEL_HEIGHT - 1) - y_ext;
            end
            ROT_270:
            begin
                px = y_ext;
                py = CALC_W'(PANEL_HEIGHT - 1) - x_ext;
            end
            default:
            begin
                px = x_ext;
                py = y_ext;
            end
        endcase

        idx_full = IDX_CALC_W'(px >> 3) + IDX_CALC_W'(py) * IDX_CALC_W'(ROW_BYTES);
        idx_ok   = idx_full < IDX_CALC_W'(STORE_DEPTH);
        bidx_ext = IDX_CALC_W'(byte_index);

        pat        = gray_pattern(color);
        color_zero = (color == '0);

        push_cmd.mask     = MSB_MASK >> px[2:0];
        push_cmd.sel_mono = mono_mode_reg;
        push_cmd.mono_val = color_zero;
        push_cmd.p1_val   = pat[0];
        push_cmd.p2_val   = pat[1];
        push_cmd.oor      = 1'b0;
        push_cmd.idx      = idx_full[ADDR_W-1:0];
        push_cmd.op       = OP_DRAW;
        push              = 1'b0;

        unique case (kind)
            KIND_DRAW:
            begin
                push_cmd.op = OP_DRAW;
                push        = accept && on_panel && idx_ok;
            end
            KIND_FILL:
            begin
                push_cmd.op = OP_FILL;
                push        = accept;
            end
            KIND_READ:
            begin
                push_cmd.op  = OP_READ;
                push_cmd.idx = bidx_ext[ADDR_W-1:0];
                push_cmd.oor = !(bidx_ext < IDX_CALC_W'(STORE_DEPTH));
                push         = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rbpp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbpp_back
// executes draw, fill and read commands against the three byte stores
// ----------------------------------------------------------------------------
module rbpp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rbpp_pkg::cmd_t                head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               done,
    output logic [rbpp_pkg::BYTE_W-1:0]        mono_byte,
    output logic [rbpp_pkg::BYTE_W-1:0]        plane_one_byte,
    output logic [rbpp_pkg::BYTE_W-1:0]        plane_two_byte
);
    import rbpp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_FILL
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic              done_reg, done_next;
    logic [BYTE_W-1:0] mono_byte_reg, mono_byte_next;
    logic [BYTE_W-1:0] p1_byte_reg, p1_byte_next;
    logic [BYTE_W-1:0] p2_byte_reg, p2_byte_next;

    logic              we_mono, we_planes;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata_mono, wdata_p1, wdata_p2;
    logic [BYTE_W-1:0] rdata_mono, rdata_p1, rdata_p2;

    rbpp_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_mono_ram (
        .clk   (clk),
        .we    (we_mono),
        .waddr (waddr),
        .wdata (wdata_mono),
        .raddr (head.idx),
        .rdata (rdata_mono)
    );

    rbpp_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_plane_one_ram (
        .clk   (clk),
        .we    (we_planes),
        .waddr (waddr),
        .wdata (wdata_p1),
        .raddr (head.idx),
        .rdata (rdata_p1)
    );

    rbpp_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_plane_two_ram (
        .clk   (clk),
        .we    (we_planes),
        .waddr (waddr),
        .wdata (wdata_p2),
        .raddr (head.idx),
        .rdata (rdata_p2)
    );

    // write side: read-modify-write for draws, constant bytes for fills
    always_comb
    begin
        we_mono    = 1'b0;
        we_planes  = 1'b0;
        waddr      = cmd_reg.idx;
        wdata_mono = (rdata_mono & ~cmd_reg.mask) | (cmd_reg.mono_val ? cmd_reg.mask : '0);
        wdata_p1   = (rdata_p1 & ~cmd_reg.mask) | (cmd_reg.p1_val ? cmd_reg.mask : '0);
        wdata_p2   = (rdata_p2 & ~cmd_reg.mask) | (cmd_reg.p2_val ? cmd_reg.mask : '0);
        if (state_reg == ST_DRAW)
        begin
            we_mono   = cmd_reg.sel_mono;
            we_planes = !cmd_reg.sel_mono;
        end
        else if (state_reg == ST_FILL)
        begin
            we_mono    = cmd_reg.sel_mono;
            we_planes  = !cmd_reg.sel_mono;
            waddr      = fill_cnt_reg;
            wdata_mono = {BYTE_W{cmd_reg.mono_val}};
            wdata_p1   = {BYTE_W{cmd_reg.p1_val}};
            wdata_p2   = {BYTE_W{cmd_reg.p2_val}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        fill_cnt_next  = fill_cnt_reg;
        done_next      = 1'b0;
        mono_byte_next = mono_byte_reg;
        p1_byte_next   = p1_byte_reg;
        p2_byte_next   = p2_byte_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.op)
                        OP_DRAW:
                        begin
                            state_next = ST_DRAW;
                        end
                        OP_FILL:
                        begin
                            fill_cnt_next = '0;
                            state_next    = ST_FILL;
                        end
                        OP_READ:
                        begin
                            if (head.oor)
                            begin
                                done_next      = 1'b1;
                                mono_byte_next = BYTE_ALL_ONES;
                                p1_byte_next   = '0;
                                p2_byte_next   = '0;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                done_next      = 1'b1;
                mono_byte_next = ~rdata_mono;
                p1_byte_next   = rdata_p1;
                p2_byte_next   = rdata_p2;
                state_next     = ST_IDLE;
            end
            ST_FILL:
            begin
                if (fill_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            fill_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            mono_byte_reg <= '0;
            p1_byte_reg   <= '0;
            p2_byte_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            fill_cnt_reg  <= fill_cnt_next;
            done_reg      <= done_next;
            mono_byte_reg <= mono_byte_next;
            p1_byte_reg   <= p1_byte_next;
            p2_byte_reg   <= p2_byte_next;
        end
    end

    assign done           = done_reg;
    assign mono_byte      = mono_byte_reg;
    assign plane_one_byte = p1_byte_reg;
    assign plane_two_byte = p2_byte_reg;

endmodule
`default_nettype wire
